[rtl/wgm_pkg.sv]
// wgm_pkg: shared types and constants for the wildcard glob matcher
// used by wgm_cell and wildcard_glob_matcher_top; no dependencies
`timescale 1ns / 1ps

package wgm_pkg;

	// default pattern capacity in characters
	localparam int PATTERN_MAX_DEF = 32;

	// operation codes
	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_APPEND  = 2'd1;
	localparam logic [1:0] OP_SUBJECT = 2'd2;
	localparam logic [1:0] OP_END     = 2'd3;

	// wildcard characters
	localparam logic [7:0] STAR_CHAR = 8'h2A;
	localparam logic [7:0] ANY_CHAR  = 8'h3F;

	// input transaction payload
	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] char_value;
	} item_t;

	// output transaction payload
	typedef struct packed {
		logic matched;
		logic overflow;
	} result_t;

	// decoded command broadcast to every cell, already qualified by accept
	typedef struct packed {
		logic       clear;
		logic       append;
		logic       subject;
		logic       finish;
		logic [7:0] ch;
	} cmd_t;

	// neighbor link, handed from each cell to the next
	typedef struct packed {
		logic used;      // this position holds a pattern character
		logic append;    // this position takes the appended character now
		logic pre_star;  // start closure reaches the next position if the new char is a star
		logic hit;       // active here and the subject character advances
		logic carry;     // active here in the next vector and this is a star
	} link_t;

endpackage

[rtl/wgm_cell.sv]
// wgm_cell: one pattern position of the glob matcher chain
// holds a pattern character, its used flag and active/start-closure bits; uses wgm_pkg
`timescale 1ns / 1ps

module wgm_cell #(
	parameter bit HEAD = 1'b0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  wgm_pkg::cmd_t  cmd,
	input  wgm_pkg::link_t left,
	output wgm_pkg::link_t right,
	output logic          end_hit
);
	import wgm_pkg::*;

	logic [7:0] char_q;
	logic       used_q;
	logic       act_q;
	logic       pre_q;

	logic is_star;
	logic advance;
	logic write_here;
	logic pre_new;
	logic act_next;

	// character classification against the stored pattern char
	assign is_star    = used_q && (char_q == STAR_CHAR);
	assign advance    = used_q && !is_star && ((char_q == ANY_CHAR) || (char_q == cmd.ch));
	assign write_here = cmd.append && left.used && !used_q;

	// next active bit with star closure rippling in from the left
	assign act_next = (act_q && is_star) || left.hit || left.carry;

	// start closure after an append at the previous position
	assign pre_new = left.append ? left.pre_star : pre_q;

	// link to the right neighbor
	always_comb begin
		right.used     = used_q;
		right.append   = write_here;
		right.pre_star = pre_q && (cmd.ch == STAR_CHAR);
		right.hit      = act_q && advance;
		right.carry    = act_next && is_star;
	end

	// this is the end-of-pattern position and it is active
	assign end_hit = act_q && left.used && !used_q;

	// pattern character store, undefined until written
	always_ff @(posedge clk) begin
		if (write_here) begin
			char_q <= cmd.ch;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			act_q  <= HEAD;
			pre_q  <= HEAD;
		end else if (cmd.clear) begin
			used_q <= 1'b0;
			act_q  <= HEAD;
			pre_q  <= HEAD;
		end else if (cmd.append) begin
			if (write_here) begin
				used_q <= 1'b1;
			end
			pre_q <= pre_new;
			act_q <= pre_new;
		end else if (cmd.subject) begin
			act_q <= act_next;
		end else if (cmd.finish) begin
			act_q <= pre_q;
		end
	end

endmodule

[rtl/wildcard_glob_matcher_top.sv]
// wildcard_glob_matcher_top: glob pattern matcher with a chain of position cells
// instantiates wgm_cell; uses wgm_pkg
`timescale 1ns / 1ps

// Usage
// Input channel item_valid/item_ready/item carries one operation per transaction:
// clear pattern, append pattern char, subject char, end of subject. The pattern
// holds up to PATTERN_MAX chars; '*' matches any run, '?' any single char.
// Appending re-arms the matcher; appending when full drops the char and sets a
// sticky overflow flag that a clear removes.
// Only end of subject produces a result transaction on result_valid/
// result_ready/result: matched and overflow. The result is valid in the cycle
// after the end transaction is accepted; the matcher is re-armed at that edge.
// One transaction per cycle is accepted in steady state, unless a result
// waits with result_ready low. All positions update in parallel; star closure
// ripples along the cell chain like a carry within the same cycle.
// The result register takes a new result while the old one is handed off, so
// item_ready drops only while a result waits and result_ready is low.
// Reset empties the pattern, clears overflow and leaves only the start
// position active; no result is pending.

module wildcard_glob_matcher_top #(
	parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  wgm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output wgm_pkg::result_t result
);
	import wgm_pkg::*;

	link_t                  link [PATTERN_MAX:0];
	logic [PATTERN_MAX-1:0] end_hit;
	logic [PATTERN_MAX-1:0] used_vec;
	cmd_t                   cmd;
	logic                   accept;
	logic                   full;
	logic                   tail_act_q;
	logic                   tail_pre_q;
	logic                   tail_pre_new;
	logic                   overflow_q;
	logic                   any_hit;
	logic                   out_valid_q;
	result_t                out_q;

	// handshake
	assign accept     = item_valid && item_ready;
	assign item_ready = !out_valid_q || result_ready;

	// decode the accepted operation
	always_comb begin
		cmd.clear   = 1'b0;
		cmd.append  = 1'b0;
		cmd.subject = 1'b0;
		cmd.finish  = 1'b0;
		cmd.ch      = item.char_value;
		if (accept) begin
			case (item.operation)
				OP_CLEAR:   cmd.clear   = 1'b1;
				OP_APPEND:  cmd.append  = 1'b1;
				OP_SUBJECT: cmd.subject = 1'b1;
				OP_END:     cmd.finish  = 1'b1;
				default:    cmd.clear   = 1'b0;
			endcase
		end
	end

	// boundary link into the first cell
	assign link[0].used     = 1'b1;
	assign link[0].append   = 1'b0;
	assign link[0].pre_star = 1'b0;
	assign link[0].hit      = 1'b0;
	assign link[0].carry    = 1'b0;

	// chain of position cells
	genvar gi;
	generate
		for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
			wgm_cell #(
				.HEAD(gi == 0)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.cmd     (cmd),
				.left    (link[gi]),
				.right   (link[gi+1]),
				.end_hit (end_hit[gi])
			);
			assign used_vec[gi] = link[gi+1].used;
		end
	endgenerate

	assign full = link[PATTERN_MAX].used;

	// final position after a full pattern
	assign tail_pre_new = link[PATTERN_MAX].append ? link[PATTERN_MAX].pre_star : tail_pre_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_act_q <= 1'b0;
			tail_pre_q <= 1'b0;
		end else if (cmd.clear) begin
			tail_act_q <= 1'b0;
			tail_pre_q <= 1'b0;
		end else if (cmd.append) begin
			tail_pre_q <= tail_pre_new;
			tail_act_q <= tail_pre_new;
		end else if (cmd.subject) begin
			tail_act_q <= link[PATTERN_MAX].hit || link[PATTERN_MAX].carry;
		end else if (cmd.finish) begin
			tail_act_q <= tail_pre_q;
		end
	end

	// sticky overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_q <= 1'b0;
		end else if (cmd.clear) begin
			overflow_q <= 1'b0;
		end else if (cmd.append && full) begin
			overflow_q <= 1'b1;
		end
	end

	// end-of-pattern position active
	assign any_hit = (|end_hit) || (tail_act_q && full);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.matched  <= any_hit && !overflow_q;
			out_q.overflow <= overflow_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// overflow forces a miss
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.matched && result.overflow))
		else $error("matched reported together with overflow");

	// an accepted end of subject yields a result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && (item.operation == OP_END)) |=> result_valid)
		else $error("end of subject produced no result");

	// used positions form a contiguous prefix
	assert property (@(posedge clk) disable iff (!arst_n)
		((PATTERN_MAX'(used_vec + 1'b1) & used_vec) == '0))
		else $error("pattern positions not filled in order");

	// the final position is active only with a full pattern
	assert property (@(posedge clk) disable iff (!arst_n)
		tail_act_q |-> full)
		else $error("final position active with a short pattern");

endmodule

[dv/tb_wildcard_glob_matcher_top.sv]
// tb_wildcard_glob_matcher_top: self-checking testbench for the wildcard glob matcher
// depends on wgm_pkg and wildcard_glob_matcher_top; predicts each end-of-subject result
// from its own copy of the pattern and the active position vector
`timescale 1ns / 1ps

module tb_wildcard_glob_matcher_top;
	import wgm_pkg::*;

	localparam int PAT_CAP = PATTERN_MAX_DEF;
	localparam int TARGET_ITEMS = 1130;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// glob predictor and store of pending match results
	class match_scoreboard;
		logic [7:0]     pat_chars [PAT_CAP];
		int unsigned    pat_len;
		logic [PAT_CAP:0] live_pos;
		bit             ovf_flag;
		result_t        match_q [$];
		int             errors;
		int             results_seen;

		function new();
			foreach (pat_chars[i]) pat_chars[i] = '0;
			pat_len = 0;
			ovf_flag = 1'b0;
			errors = 0;
			results_seen = 0;
			rearm();
		endfunction

		function void rearm();
			live_pos = '0;
			live_pos[0] = 1'b1;
		endfunction

		// an active star also activates the position after it
		function logic [PAT_CAP:0] close_stars(logic [PAT_CAP:0] v);
			for (int i = 0; i < pat_len; i++) begin
				if (v[i] && pat_chars[i] == STAR_CHAR)
					v[i + 1] = 1'b1;
			end
			return v;
		endfunction

		// advance the predictor by one accepted input transaction
		function void note_input(item_t it);
			logic [PAT_CAP:0] nxt;
			result_t exp_res;
			case (it.operation)
				OP_CLEAR: begin
					pat_len = 0;
					ovf_flag = 1'b0;
					rearm();
				end
				OP_APPEND: begin
					if (pat_len < PAT_CAP) begin
						pat_chars[pat_len] = it.char_value;
						pat_len++;
					end else begin
						ovf_flag = 1'b1;
					end
					rearm();
				end
				OP_SUBJECT: begin
					nxt = '0;
					live_pos = close_stars(live_pos);
					for (int i = 0; i < pat_len; i++) begin
						if (live_pos[i]) begin
							if (pat_chars[i] == STAR_CHAR)
								nxt[i] = 1'b1;
							else if (pat_chars[i] == ANY_CHAR || pat_chars[i] == it.char_value)
								nxt[i + 1] = 1'b1;
						end
					end
					live_pos = close_stars(nxt);
				end
				OP_END: begin
					live_pos = close_stars(live_pos);
					exp_res.matched = live_pos[pat_len] && !ovf_flag;
					exp_res.overflow = ovf_flag;
					match_q.push_back(exp_res);
					rearm();
				end
				default: ;
			endcase
		endfunction

		// compare one result transaction with the oldest prediction
		function void check_result(result_t got);
			result_t exp_res;
			results_seen++;
			if (match_q.size() == 0) begin
				$error("result with nothing expected: matched %0b overflow %0b",
					got.matched, got.overflow);
				errors++;
			end else begin
				exp_res = match_q.pop_front();
				if (got.matched !== exp_res.matched) begin
					$error("matched: expected %0b, actual %0b", exp_res.matched, got.matched);
					errors++;
				end
				if (got.overflow !== exp_res.overflow) begin
					$error("overflow: expected %0b, actual %0b", exp_res.overflow, got.overflow);
					errors++;
				end
			end
		endfunction
	endclass

	match_scoreboard sb = new();
	int items_sent = 0;
	int burst_left = 0;

	wildcard_glob_matcher_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	// offer one transaction and hold it until accepted; idle gaps between bursts
	task automatic send_item(logic [1:0] op, logic [7:0] ch);
		item_t it;
		it.operation = op;
		it.char_value = ch;
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		sb.note_input(it);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(0, 30);
		end
	endtask

	// character mix biased toward a tiny alphabet so that matches happen
	function automatic logic [7:0] pick_char();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r < 6)
			return 8'h61 + 8'(r % 2);
		else if (r < 8)
			return 8'h63;
		else if (r < 10)
			return STAR_CHAR;
		else if (r < 12)
			return ANY_CHAR;
		else if (r == 12)
			return 8'h00;
		else if (r == 13)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// clear, build a pattern, then stream one to four subjects against it
	task automatic run_glob_session();
		logic [7:0] pat [$];
		logic [7:0] subj [$];
		logic [7:0] ch;
		int unsigned r;
		int unsigned plen;
		send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
		r = $urandom_range(0, 19);
		if (r < 14)
			plen = $urandom_range(0, 6);
		else if (r < 18)
			plen = $urandom_range(7, PAT_CAP);
		else
			plen = $urandom_range(PAT_CAP + 1, PAT_CAP + 4);
		repeat (plen) begin
			ch = pick_char();
			pat.push_back(ch);
			send_item(OP_APPEND, ch);
		end
		repeat ($urandom_range(1, 4)) begin
			subj.delete();
			if ($urandom_range(0, 2) != 0) begin
				// subject derived from the pattern, wildcards expanded at random
				foreach (pat[i]) begin
					if (pat[i] == STAR_CHAR)
						repeat ($urandom_range(0, 3)) subj.push_back(pick_char());
					else if (pat[i] == ANY_CHAR)
						subj.push_back(8'($urandom_range(0, 255)));
					else
						subj.push_back(pat[i]);
				end
				if (subj.size() > 0 && $urandom_range(0, 3) == 0)
					subj[$urandom_range(0, subj.size() - 1)] = pick_char();
			end else begin
				repeat ($urandom_range(0, 8)) subj.push_back(pick_char());
			end
			foreach (subj[i]) begin
				// now and then an append lands in the middle of a subject
				if ($urandom_range(0, 39) == 0) begin
					ch = pick_char();
					pat.push_back(ch);
					send_item(OP_APPEND, ch);
				end
				send_item(OP_SUBJECT, subj[i]);
			end
			send_item(OP_END, 8'($urandom_range(0, 255)));
		end
	endtask

	// stimulus
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern against empty and non-empty subjects
		send_item(OP_END, 8'hFF);
		send_item(OP_SUBJECT, 8'h00);
		send_item(OP_END, 8'h00);
		// byte zero, star, all-ones byte and any-char in one pattern
		send_item(OP_APPEND, 8'h00);
		send_item(OP_APPEND, STAR_CHAR);
		send_item(OP_APPEND, 8'hFF);
		send_item(OP_APPEND, ANY_CHAR);
		send_item(OP_SUBJECT, 8'h00);
		send_item(OP_SUBJECT, 8'hFF);
		send_item(OP_SUBJECT, 8'h41);
		send_item(OP_END, 8'h00);
		send_item(OP_SUBJECT, 8'h00);
		send_item(OP_END, 8'hFF);
		// append during a subject restarts it
		send_item(OP_CLEAR, 8'hFF);
		send_item(OP_APPEND, 8'h61);
		send_item(OP_SUBJECT, 8'h62);
		send_item(OP_APPEND, STAR_CHAR);
		send_item(OP_SUBJECT, 8'h61);
		send_item(OP_END, 8'h00);
		// lone star matches the empty subject
		send_item(OP_CLEAR, 8'h00);
		send_item(OP_APPEND, STAR_CHAR);
		send_item(OP_END, 8'h00);

		// random sessions mixed with noise
		while (items_sent < TARGET_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(3, 12))
					send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else begin
				run_glob_session();
			end
		end

		// drain
		item_valid <= 1'b0;
		while (sb.match_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// result side: check and stall, with one long hold-off to back up the input
	initial begin
		int cyc;
		int hold_left;
		bit hold_done;
		cyc = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (result_valid && result_ready)
				sb.check_result(result);
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (!hold_done && sb.results_seen >= 20) begin
				hold_done = 1'b1;
				hold_left = 400;
				result_ready <= 1'b0;
			end else if (cyc[8]) begin
				result_ready <= ($urandom_range(0, 2) != 0);
			end else if (cyc[7]) begin
				result_ready <= ($urandom_range(0, 7) == 0);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/wgm_pkg.sv
rtl/wgm_cell.sv
rtl/wildcard_glob_matcher_top.sv
dv/tb_wildcard_glob_matcher_top.sv
